[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks on clk_i under rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent are checked in the same cycle.
`define BBC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define BBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bbc_pkg.sv]
// ----------------------------------------------------------------------------
// bbc_pkg
// Types, character codes and status codes of the bracket balance checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int unsigned StackDepthDefault = 64;
  localparam int unsigned QueueDepth        = 2;

  localparam logic [7:0] ChRoundOpen   = 8'h28;  // (
  localparam logic [7:0] ChRoundClose  = 8'h29;  // )
  localparam logic [7:0] ChSquareOpen  = 8'h5B;  // [
  localparam logic [7:0] ChSquareClose = 8'h5D;  // ]
  localparam logic [7:0] ChCurlyOpen   = 8'h7B;  // {
  localparam logic [7:0] ChCurlyClose  = 8'h7D;  // }

  typedef enum logic [1:0] {
    KIND_ROUND  = 2'd0,
    KIND_CURLY  = 2'd1,
    KIND_SQUARE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_BALANCED = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_UNCLOSED = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // One classified character as it travels from the front to the back end.
  typedef struct packed {
    op_e   op;
    kind_e kind;
    logic  last;
  } item_t;

endpackage

[rtl/bbc_front.sv]
// ----------------------------------------------------------------------------
// bbc_front
// Classifies an incoming byte into push, pop or no operation.
// ----------------------------------------------------------------------------
module bbc_front (
  input  logic [7:0]     char_byte_i,
  input  logic           char_valid_i,
  input  logic           last_char_i,
  output bbc_pkg::item_t item_o
);

  // Only a byte that holds a character can push or pop; every other byte,
  // and an end-only transaction, passes as no operation.
  always_comb begin
    item_o.op   = bbc_pkg::OP_NONE;
    item_o.kind = bbc_pkg::KIND_ROUND;
    item_o.last = last_char_i;
    if (char_valid_i) begin
      unique case (char_byte_i)
        bbc_pkg::ChRoundOpen: begin
          item_o.op   = bbc_pkg::OP_PUSH;
          item_o.kind = bbc_pkg::KIND_ROUND;
        end
        bbc_pkg::ChCurlyOpen: begin
          item_o.op   = bbc_pkg::OP_PUSH;
          item_o.kind = bbc_pkg::KIND_CURLY;
        end
        bbc_pkg::ChSquareOpen: begin
          item_o.op   = bbc_pkg::OP_PUSH;
          item_o.kind = bbc_pkg::KIND_SQUARE;
        end
        bbc_pkg::ChRoundClose: begin
          item_o.op   = bbc_pkg::OP_POP;
          item_o.kind = bbc_pkg::KIND_ROUND;
        end
        bbc_pkg::ChCurlyClose: begin
          item_o.op   = bbc_pkg::OP_POP;
          item_o.kind = bbc_pkg::KIND_CURLY;
        end
        bbc_pkg::ChSquareClose: begin
          item_o.op   = bbc_pkg::OP_POP;
          item_o.kind = bbc_pkg::KIND_SQUARE;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/bbc_queue.sv]
// ----------------------------------------------------------------------------
// bbc_queue
// Short first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
module bbc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  bbc_pkg::item_t wr_item_i,
  output logic           full_o,
  input  logic           rd_en_i,
  output logic           rd_valid_o,
  output bbc_pkg::item_t rd_item_o
);

  localparam int unsigned PtrW = (bbc_pkg::QueueDepth > 1) ? $clog2(bbc_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(bbc_pkg::QueueDepth + 1);

  bbc_pkg::item_t slot_q [bbc_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] fill_q, fill_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(bbc_pkg::QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  assign full_o     = (fill_q == CntW'(bbc_pkg::QueueDepth));
  assign rd_valid_o = (fill_q != '0);
  assign rd_item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = rd_en_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    fill_d   = fill_q;
    if (wr_en_i && !rd_en_i) begin
      fill_d = fill_q + CntW'(1);
    end else if (!wr_en_i && rd_en_i) begin
      fill_d = fill_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      slot_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

[rtl/bbc_exec.sv]
// ----------------------------------------------------------------------------
// bbc_exec
// Back end: runs push and pop on the opener stack and issues the status.
// ----------------------------------------------------------------------------
module bbc_exec #(
  parameter int unsigned STACK_DEPTH = bbc_pkg::StackDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  bbc_pkg::item_t item_i,
  output logic           item_take_o,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output logic [1:0]     status_o,
  output logic           balanced_o
);

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);

  // The top entry lives in top_q; the memory holds the entries below it,
  // and below_q holds the entry right under the top for the next pop.
  logic [1:0]       stack_mem [STACK_DEPTH];
  logic [CntW-1:0]  cnt_q, cnt_d;
  bbc_pkg::kind_e   top_q, top_d;
  logic [1:0]       below_q;
  logic             fail_q, fail_d;
  bbc_pkg::status_e cause_q, cause_d;
  logic             res_valid_q;
  bbc_pkg::status_e res_status_q;
  bbc_pkg::status_e status_now;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [CntW-1:0]  rd_cnt;
  logic [AddrW-1:0] rd_addr;
  logic [CntW-1:0]  wr_cnt;

  // A last item waits while an earlier status has not been taken.
  assign item_take_o = item_valid_i && !(item_i.last && res_valid_q && !res_ready_i);

  always_comb begin
    cnt_d   = cnt_q;
    top_d   = top_q;
    fail_d  = fail_q;
    cause_d = cause_q;
    wr_en   = 1'b0;
    if (item_take_o && !fail_q) begin
      unique case (item_i.op)
        bbc_pkg::OP_PUSH: begin
          if (cnt_q == CntW'(STACK_DEPTH)) begin
            fail_d  = 1'b1;
            cause_d = bbc_pkg::ST_OVERFLOW;
          end else begin
            wr_en = (cnt_q != '0);
            top_d = item_i.kind;
            cnt_d = cnt_q + CntW'(1);
          end
        end
        bbc_pkg::OP_POP: begin
          if (cnt_q != '0 && top_q == item_i.kind) begin
            cnt_d = cnt_q - CntW'(1);
            top_d = bbc_pkg::kind_e'(below_q);
          end else begin
            fail_d  = 1'b1;
            cause_d = bbc_pkg::ST_MISMATCH;
          end
        end
        default: begin
        end
      endcase
    end

    if (fail_d) begin
      status_now = cause_d;
    end else if (cnt_d != '0) begin
      status_now = bbc_pkg::ST_UNCLOSED;
    end else begin
      status_now = bbc_pkg::ST_BALANCED;
    end

    if (item_take_o && item_i.last) begin
      cnt_d   = '0;
      fail_d  = 1'b0;
      cause_d = bbc_pkg::ST_BALANCED;
    end
  end

  assign wr_cnt  = cnt_q - CntW'(1);
  assign wr_addr = wr_cnt[AddrW-1:0];
  assign rd_cnt  = cnt_d - CntW'(2);
  assign rd_addr = rd_cnt[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= top_q;
    end
  end

  // Read the entry under the next top; a spill to the same place this
  // cycle is forwarded.
  always_ff @(posedge clk_i) begin
    if (wr_en && wr_addr == rd_addr) begin
      below_q <= top_q;
    end else begin
      below_q <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      top_q        <= bbc_pkg::KIND_ROUND;
      fail_q       <= 1'b0;
      cause_q      <= bbc_pkg::ST_BALANCED;
      res_valid_q  <= 1'b0;
      res_status_q <= bbc_pkg::ST_BALANCED;
    end else begin
      cnt_q   <= cnt_d;
      top_q   <= top_d;
      fail_q  <= fail_d;
      cause_q <= cause_d;
      if (item_take_o && item_i.last) begin
        res_valid_q  <= 1'b1;
        res_status_q <= status_now;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign status_o    = res_status_q;
  assign balanced_o  = (res_status_q == bbc_pkg::ST_BALANCED);

endmodule

[rtl/bracket_balance_checker_core.sv]
// ----------------------------------------------------------------------------
// bracket_balance_checker_core
// Streaming checker for balanced round, curly and square brackets.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle, unless stalled as described below, and
// gives one status transaction at the end of each string. Without a stall it
// sustains one input transaction per clock cycle: a push or pop touches only
// the top of stack, which sits in a register, while the entry below it is
// prefetched from the stack memory into a register ahead of the next pop. The
// last byte reaches its status through the front queue, then the stack update
// and the status register, which are written at the same edge. Input is
// stalled only when the status register still holds an unread result and a
// further string end reaches the stack unit; the two-entry queue then absorbs the input until it fills.
// The stack memory needs no clearing pass, since entries above the count are
// never used. After reset the block is ready at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bracket_balance_checker_core #(
  parameter int unsigned STACK_DEPTH = bbc_pkg::StackDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_byte
  input  logic       s_axis_tuser,   // [0] char_valid
  input  logic       s_axis_tlast,   // last_char
  // Status stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [1:0] status, [2] balanced, [7:3] zero
);

  bbc_pkg::item_t front_item;
  bbc_pkg::item_t q_item;
  logic           q_full;
  logic           q_wr;
  logic           q_valid;
  logic           q_take;
  logic [1:0]     status;
  logic           balanced;
  logic           res_hold;
  logic           res_take;
  logic           q_end;
  logic           bal_ok;

  // Front end: classify the byte.
  bbc_front u_front (
    .char_byte_i  (s_axis_tdata),
    .char_valid_i (s_axis_tuser),
    .last_char_i  (s_axis_tlast),
    .item_o       (front_item)
  );

  assign s_axis_tready = !q_full;
  assign q_wr          = s_axis_tvalid && s_axis_tready;

  bbc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (q_wr),
    .wr_item_i  (front_item),
    .full_o     (q_full),
    .rd_en_i    (q_take),
    .rd_valid_o (q_valid),
    .rd_item_o  (q_item)
  );

  // Back end: stack and status register.
  bbc_exec #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_exec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_take_o  (q_take),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .status_o     (status),
    .balanced_o   (balanced)
  );

  assign m_axis_tdata = {5'b0, balanced, status};

  // Terms used by the checks below.
  assign res_hold = m_axis_tvalid && !m_axis_tready;
  assign res_take = m_axis_tvalid && m_axis_tready;
  assign q_end    = q_valid && q_item.last;
  assign bal_ok   = (balanced == (status == bbc_pkg::ST_BALANCED));

  // A new string end must not overwrite a status that is still waiting.
  `BBC_ASSERT_SAME(a_no_status_overwrite, res_hold && q_end, !q_take, "status overwritten")
  // The balanced flag follows the status code.
  `BBC_ASSERT_SAME(a_balanced_matches, m_axis_tvalid, bal_ok, "balanced flag disagrees")
  // A taken status with no new string end leaves the output empty.
  `BBC_ASSERT_NEXT(a_status_drains, res_take && !(q_take && q_end), !m_axis_tvalid, "status repeated")

endmodule

[tb/sv/bbc_scoreboard.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_scoreboard
// Bracket nesting predictor and status scoreboard for the checker testbench.
// ----------------------------------------------------------------------------
package bbc_tb_pkg;

  import bbc_pkg::*;

  class bracket_scoreboard;

    int unsigned stack_limit;
    kind_e       open_kinds[];
    int unsigned open_count;
    bit          string_failed;
    status_e     first_cause;
    status_e     status_q[$];
    int unsigned errors;
    int unsigned chars_noted;
    int unsigned strings_noted;
    int unsigned deepest;
    int unsigned status_seen[4];

    function new(int unsigned depth);
      stack_limit = depth;
      open_kinds  = new[depth];
      clear_string();
    endfunction

    function void clear_string();
      open_count    = 0;
      string_failed = 1'b0;
      first_cause   = ST_BALANCED;
    endfunction

    function void fail_string(status_e cause);
      string_failed = 1'b1;
      first_cause   = cause;
    endfunction

    // Updates the nesting state with one accepted input transaction and, at
    // the end of a string, queues the status that the block must report.
    function void note_input(logic [7:0] ch, logic ch_valid, logic ch_last);
      kind_e   k;
      bit      is_open;
      bit      is_close;
      status_e st;
      k        = KIND_ROUND;
      is_open  = 1'b0;
      is_close = 1'b0;
      if (ch_valid || ch_last) begin
        chars_noted++;
      end
      case (ch)
        ChRoundOpen: begin
          k = KIND_ROUND;  is_open = 1'b1;
        end
        ChCurlyOpen: begin
          k = KIND_CURLY;  is_open = 1'b1;
        end
        ChSquareOpen: begin
          k = KIND_SQUARE; is_open = 1'b1;
        end
        ChRoundClose: begin
          k = KIND_ROUND;  is_close = 1'b1;
        end
        ChCurlyClose: begin
          k = KIND_CURLY;  is_close = 1'b1;
        end
        ChSquareClose: begin
          k = KIND_SQUARE; is_close = 1'b1;
        end
        default: begin
        end
      endcase
      if (ch_valid && !string_failed) begin
        if (is_open) begin
          if (open_count >= stack_limit) begin
            fail_string(ST_OVERFLOW);
          end else begin
            open_kinds[open_count] = k;
            open_count++;
            if (open_count > deepest) begin
              deepest = open_count;
            end
          end
        end else if (is_close) begin
          if (open_count > 0 && open_kinds[open_count - 1] == k) begin
            open_count--;
          end else begin
            fail_string(ST_MISMATCH);
          end
        end
      end
      if (ch_last) begin
        if (string_failed) begin
          st = first_cause;
        end else if (open_count > 0) begin
          st = ST_UNCLOSED;
        end else begin
          st = ST_BALANCED;
        end
        status_q.push_back(st);
        status_seen[st]++;
        strings_noted++;
        clear_string();
      end
    endfunction

    // Compares one status transaction with the oldest queued status.
    function void check_result(logic [7:0] data);
      status_e want;
      logic    want_bal;
      if (status_q.size() == 0) begin
        $error("unexpected status transaction, tdata %h", data);
        errors++;
        return;
      end
      want     = status_q.pop_front();
      want_bal = (want == ST_BALANCED);
      if (data[1:0] !== want) begin
        $error("status: expected %0d, actual %0d", want, data[1:0]);
        errors++;
      end
      if (data[2] !== want_bal) begin
        $error("balanced: expected %0d, actual %0d", want_bal, data[2]);
        errors++;
      end
      if (data[7:3] !== 5'd0) begin
        $error("padding: expected 0, actual %h", data[7:3]);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return status_q.size();
    endfunction

  endclass

endpackage

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for bracket_balance_checker_core: directed strings for the
// status cases, then random nested, corrupted, deep and noise strings with
// random gaps on the input side and random stalls on the status side.
// ----------------------------------------------------------------------------
module testbench;

  import bbc_pkg::*;
  import bbc_tb_pkg::*;

  localparam int unsigned TargetChars = 850;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tuser;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;

  bracket_scoreboard status_board;

  logic [7:0]  text[$];
  bit          sender_calm;
  int unsigned chars_sent;
  int unsigned deep_count;
  int unsigned ready_left;
  int unsigned ready_roll;
  bit          ready_next;

  bracket_balance_checker_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #10 clk_i = ~clk_i;
  end

  function automatic logic [7:0] open_char(kind_e k);
    case (k)
      KIND_CURLY:  return ChCurlyOpen;
      KIND_SQUARE: return ChSquareOpen;
      default:     return ChRoundOpen;
    endcase
  endfunction

  function automatic logic [7:0] close_char(kind_e k);
    case (k)
      KIND_CURLY:  return ChCurlyClose;
      KIND_SQUARE: return ChSquareClose;
      default:     return ChRoundClose;
    endcase
  endfunction

  function automatic bit is_bracket(logic [7:0] ch);
    return ch == ChRoundOpen || ch == ChRoundClose || ch == ChCurlyOpen ||
           ch == ChCurlyClose || ch == ChSquareOpen || ch == ChSquareClose;
  endfunction

  // Mostly printable non-bracket text, sometimes any byte at all.
  function automatic logic [7:0] filler_byte();
    logic [7:0] ch;
    if ($urandom_range(0, 9) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    ch = 8'($urandom_range(32, 126));
    while (is_bracket(ch)) begin
      ch = 8'($urandom_range(32, 126));
    end
    return ch;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (sender_calm) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 30);
  endfunction

  // Offers one input transaction after a random gap and waits until the
  // block takes it. tvalid stays high when the next call has no gap.
  task automatic send_item(logic [7:0] ch, logic ch_valid, logic ch_last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= ch_valid;
    s_axis_tlast  <= ch_last;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    status_board.note_input(ch, ch_valid, ch_last);
    if (ch_valid || ch_last) begin
      chars_sent++;
    end
  endtask

  // Sends the bytes in text as one string. The end is marked either on the
  // final character or by a separate end-only transaction; now and then an
  // ignored transaction with neither flag slips in between.
  task automatic send_string(bit end_marker);
    int unsigned n;
    bit          last_on_char;
    n = text.size();
    last_on_char = !end_marker && n > 0;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_item(text[i], 1'b1, last_on_char && i == n - 1);
    end
    if (!last_on_char) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  task automatic send_text(string s, bit end_marker);
    text = {};
    foreach (s[i]) begin
      text.push_back(s[i]);
    end
    send_string(end_marker);
  endtask

  // Random nesting with text in between. A corrupted closer names another
  // kind, and leaving openers unclosed gives the unclosed status.
  task automatic build_nested(int unsigned max_depth, int unsigned len, bit close_all,
                              int unsigned corrupt_pct);
    kind_e       open_q[$];
    kind_e       k;
    int unsigned roll;
    text = {};
    repeat (len) begin
      roll = $urandom_range(0, 99);
      if (roll < 40 && open_q.size() < max_depth) begin
        k = kind_e'($urandom_range(0, 2));
        open_q.push_back(k);
        text.push_back(open_char(k));
      end else if (roll < 75 && open_q.size() > 0) begin
        k = open_q.pop_back();
        if ($urandom_range(0, 99) < corrupt_pct) begin
          k = kind_e'((int'(k) + 1 + $urandom_range(0, 1)) % 3);
        end
        text.push_back(close_char(k));
      end else begin
        text.push_back(filler_byte());
      end
    end
    if (close_all) begin
      while (open_q.size() > 0) begin
        text.push_back(close_char(open_q.pop_back()));
      end
    end
  endtask

  // A run of openers to the given depth, then matching closers. Beyond the
  // stack depth this overflows; at exactly the depth it does not overflow.
  task automatic build_deep(int unsigned depth, bit leave_one);
    kind_e open_q[$];
    kind_e k;
    text = {};
    repeat (depth) begin
      k = kind_e'($urandom_range(0, 2));
      open_q.push_back(k);
      text.push_back(open_char(k));
    end
    while (open_q.size() > (leave_one ? 1 : 0)) begin
      text.push_back(close_char(open_q.pop_back()));
    end
  endtask

  task automatic build_noise(int unsigned len);
    logic [7:0] brackets[6];
    brackets = '{ChRoundOpen, ChRoundClose, ChCurlyOpen, ChCurlyClose,
                 ChSquareOpen, ChSquareClose};
    text = {};
    repeat (len) begin
      if ($urandom_range(0, 1) == 0) begin
        text.push_back(brackets[$urandom_range(0, 5)]);
      end else begin
        text.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic drain_status();
    s_axis_tvalid <= 1'b0;
    while (status_board.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Status side: random stalls, mostly short, a few long, and stretches with
  // tready held high.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      ready_left = 0;
    end else begin
      if (ready_left == 0) begin
        ready_roll = $urandom_range(0, 99);
        if (ready_roll < 20) begin
          ready_next = 1'b1;
          ready_left = $urandom_range(20, 60);
        end else if (ready_roll < 65) begin
          ready_next = 1'b1;
          ready_left = $urandom_range(1, 4);
        end else if (ready_roll < 93) begin
          ready_next = 1'b0;
          ready_left = $urandom_range(1, 3);
        end else begin
          ready_next = 1'b0;
          ready_left = $urandom_range(10, 40);
        end
      end
      m_axis_tready <= ready_next;
      ready_left--;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      status_board.check_result(m_axis_tdata);
    end
  end

  initial begin
    int unsigned str_idx;
    int unsigned roll;
    bit          end_marker;
    status_board  = new(StackDepthDefault);
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tuser  <= 1'b0;
    s_axis_tlast  <= 1'b0;
    sender_calm   = 1'b0;
    chars_sent    = 0;
    deep_count    = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed strings: empty string, balanced with the end on a closer,
    // wrong closer kind, closer on an empty stack, an opener left open with
    // a separate end transaction, and a failure whose cause must survive
    // the later openers.
    send_text("", 1'b1);
    send_text("([{}])", 1'b0);
    send_text("(]", 1'b0);
    send_text(")", 1'b0);
    send_text("{a", 1'b1);
    send_text("]([", 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    drain_status();

    str_idx = 0;
    while (chars_sent < TargetChars) begin
      str_idx++;
      sender_calm = ($urandom_range(0, 3) == 0);
      if (str_idx == 20) begin
        drain_status();
      end
      roll = $urandom_range(0, 99);
      if (str_idx % 12 == 5) begin
        // The first two deep strings fill the stack exactly, then overflow.
        if (deep_count == 0) begin
          build_deep(StackDepthDefault, 1'b0);
        end else if (deep_count == 1) begin
          build_deep(StackDepthDefault + 1, 1'b0);
        end else begin
          build_deep($urandom_range(StackDepthDefault - 4, StackDepthDefault + 6),
                     $urandom_range(0, 3) == 0);
        end
        deep_count++;
      end else if (roll < 70) begin
        build_nested($urandom_range(1, 8), $urandom_range(1, 20),
                     $urandom_range(0, 4) != 0, 8);
        if ($urandom_range(0, 9) == 0) begin
          text.push_back(close_char(kind_e'($urandom_range(0, 2))));
        end
      end else if (roll < 85) begin
        build_noise($urandom_range(1, 12));
      end else if (roll < 92) begin
        text = {};
      end else begin
        text = {};
        text.push_back($urandom_range(0, 1) ? filler_byte()
                                            : close_char(kind_e'($urandom_range(0, 2))));
      end
      end_marker = text.size() == 0 || $urandom_range(0, 3) == 0;
      send_string(end_marker);
    end

    drain_status();
    repeat (10) @(posedge clk_i);

    $display("Covered %0d strings in %0d character or end transactions, nesting up to %0d.",
             status_board.strings_noted, status_board.chars_noted, status_board.deepest);
    $display("Statuses: %0d balanced, %0d bad closer, %0d unclosed, %0d overflow.",
             status_board.status_seen[ST_BALANCED], status_board.status_seen[ST_MISMATCH],
             status_board.status_seen[ST_UNCLOSED], status_board.status_seen[ST_OVERFLOW]);
    if (status_board.errors == 0 && status_board.pending() == 0) begin
      $display("bracket_balance_checker_core regression: pass");
    end else begin
      $display("bracket_balance_checker_core regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("Timeout with %0d status transactions outstanding.", status_board.pending());
    $display("bracket_balance_checker_core regression: fail");
    $finish;
  end

endmodule
